### hdl/htt_pkg.sv
package htt_pkg;

    // token kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // result tuser layout, lowest bit up
    localparam int U_KIND_LSB = 0;
    localparam int U_BEGIN    = 2;
    localparam int U_DONE     = 3;
    localparam int U_W        = 4;

    // markup characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // most results one document byte can cause
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tbyte;
        logic       begins;
        logic       done;
        logic       last;
    } res_t;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_alpha(b) || ((b >= 8'h30) && (b <= 8'h39));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return is_upper(b) ? (b | 8'h20) : b;
    endfunction

    function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] tbyte,
                                    input logic begins, input logic done);
        res_t r;
        r.kind   = kind;
        r.tbyte  = tbyte;
        r.begins = begins;
        r.done   = done;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

### hdl/html_tag_text_tokenizer.sv
// channel  | direction | tdata             | tuser (low bit up)                     | tlast
// s_       | in        | data_byte[7:0]    | -                                      | end_mark
// m_       | out       | token_byte[7:0]   | token_kind[1:0], begins_token, done    | last
//
// one document byte per cycle while m_tready is high; a byte that gives one result or none
// is taken every cycle; a byte that gives n results (at most 4, after a failed "<", "<!"
// or "<!-" lookahead or at end of document) holds the input side while the result buffer
// drains one result per cycle while m_tready is high, until its last result is taken
// aresetn is synchronous, active low, and clears the scanner and the result buffer
// a stall on m_ holds the current result; s_tready falls until the buffer can take a request
module html_tag_text_tokenizer
    import htt_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // data_byte[7:0]
    input  logic           s_tlast,   // end_mark
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // token_byte[7:0]
    output logic [U_W-1:0] m_tuser,   // token_kind[1:0], begins_token, stream_done
    output logic           m_tlast    // last result of this request
);

    // scanner modes
    localparam logic [3:0] M_TEXT      = 4'd0;
    localparam logic [3:0] M_LT        = 4'd1;
    localparam logic [3:0] M_LT_BANG   = 4'd2;
    localparam logic [3:0] M_LT_BANG_D = 4'd3;
    localparam logic [3:0] M_OPEN      = 4'd4;
    localparam logic [3:0] M_CLOSE     = 4'd5;
    localparam logic [3:0] M_SKIP      = 4'd6;
    localparam logic [3:0] M_COMMENT   = 4'd7;

    logic [3:0] mode_reg,  mode_next;
    logic [1:0] dash_reg,  dash_next;
    logic       tto_reg,   tto_next;
    logic       cns_reg,   cns_next;

    res_t       res_reg   [MAX_RES];
    res_t       res_new   [MAX_RES];
    logic [2:0] n_new;
    logic [2:0] cnt_reg,  cnt_next;
    logic [1:0] rd_reg,   rd_next;

    logic       s_acc, m_acc;
    res_t       cur;

    // result buffer handshake
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign cur     = res_reg[rd_reg];
    assign m_tdata = cur.tbyte;
    assign m_tuser = {cur.done, cur.begins, cur.kind};
    assign m_tlast = cur.last;

    // scan one byte: next state and up to four results
    always_comb begin
        logic [7:0] b;
        logic       do_flush;
        logic       do_feed;
        logic [2:0] n;
        b         = s_tdata;
        do_flush  = 1'b0;
        do_feed   = 1'b0;
        n         = 3'd0;
        mode_next = mode_reg;
        dash_next = dash_reg;
        tto_next  = tto_reg;
        cns_next  = cns_reg;
        for (int i = 0; i < MAX_RES; i++) begin
            res_new[i] = mk_res(KIND_TEXT, 8'h00, 1'b0, 1'b0);
        end

        if (s_tlast) begin
            do_flush = (mode_reg == M_LT) || (mode_reg == M_LT_BANG)
                       || (mode_reg == M_LT_BANG_D);
        end else begin
            case (mode_reg)
                M_LT: begin
                    if (b == CH_BANG) begin
                        mode_next = M_LT_BANG;
                    end else if (b == CH_SLASH) begin
                        mode_next = M_CLOSE;
                        cns_next  = 1'b0;
                    end else if (is_alpha(b)) begin
                        mode_next  = M_OPEN;
                        res_new[0] = mk_res(KIND_OPEN, to_lower(b), 1'b1, 1'b0);
                        n          = 3'd1;
                    end else begin
                        do_flush = 1'b1;
                        do_feed  = 1'b1;
                    end
                end
                M_LT_BANG: begin
                    if (b == CH_DASH) begin
                        mode_next = M_LT_BANG_D;
                    end else begin
                        do_flush = 1'b1;
                        do_feed  = 1'b1;
                    end
                end
                M_LT_BANG_D: begin
                    if (b == CH_DASH) begin
                        mode_next = M_COMMENT;
                        dash_next = 2'd0;
                    end else begin
                        do_flush = 1'b1;
                        do_feed  = 1'b1;
                    end
                end
                M_OPEN: begin
                    if (is_alnum(b)) begin
                        res_new[0] = mk_res(KIND_OPEN, to_lower(b), 1'b0, 1'b0);
                        n          = 3'd1;
                    end else begin
                        mode_next = (b == CH_GT) ? M_TEXT : M_SKIP;
                    end
                end
                M_CLOSE: begin
                    if (is_alnum(b)) begin
                        res_new[0] = mk_res(KIND_CLOSE, to_lower(b), !cns_reg, 1'b0);
                        n          = 3'd1;
                        cns_next   = 1'b1;
                    end else begin
                        mode_next = (b == CH_GT) ? M_TEXT : M_SKIP;
                    end
                end
                M_SKIP: begin
                    if (b == CH_GT) begin
                        mode_next = M_TEXT;
                    end
                end
                M_COMMENT: begin
                    if (b == CH_DASH) begin
                        if (dash_reg < 2'd2) begin
                            dash_next = dash_reg + 2'd1;
                        end
                    end else if ((b == CH_GT) && (dash_reg >= 2'd2)) begin
                        mode_next = M_TEXT;
                        dash_next = 2'd0;
                    end else begin
                        dash_next = 2'd0;
                    end
                end
                default: begin
                    mode_next = M_TEXT;
                    do_feed   = 1'b1;
                end
            endcase
        end

        // held lookahead comes out as text
        if (do_flush) begin
            res_new[n[1:0]] = mk_res(KIND_TEXT, CH_LT, 1'b1, 1'b0);
            n               = n + 3'd1;
            tto_next        = 1'b0;
            if ((mode_reg == M_LT_BANG) || (mode_reg == M_LT_BANG_D)) begin
                res_new[n[1:0]] = mk_res(KIND_TEXT, CH_BANG, 1'b1, 1'b0);
                n               = n + 3'd1;
                tto_next        = 1'b1;
            end
            if (mode_reg == M_LT_BANG_D) begin
                res_new[n[1:0]] = mk_res(KIND_TEXT, CH_DASH, 1'b0, 1'b0);
                n               = n + 3'd1;
            end
            mode_next = M_TEXT;
        end

        // plain text byte
        if (do_feed) begin
            if (b == CH_LT) begin
                mode_next = M_LT;
                tto_next  = 1'b0;
            end else begin
                res_new[n[1:0]] = mk_res(KIND_TEXT, b, !tto_next, 1'b0);
                n               = n + 3'd1;
                tto_next        = 1'b1;
            end
        end

        // end of document: done marker and back to reset state
        if (s_tlast) begin
            res_new[n[1:0]] = mk_res(KIND_TEXT, 8'h00, 1'b0, 1'b1);
            n               = n + 3'd1;
            mode_next       = M_TEXT;
            dash_next       = 2'd0;
            tto_next        = 1'b0;
            cns_next        = 1'b0;
        end

        // mark the final result
        if (n != 3'd0) begin
            res_new[n[1:0] - 2'd1].last = 1'b1;
        end
        n_new = n;
    end

    // buffer count and read pointer
    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (m_acc) begin
            cnt_next = cnt_reg - 3'd1;
            rd_next  = rd_reg + 2'd1;
        end
        if (s_acc) begin
            cnt_next = n_new;
            rd_next  = 2'd0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_TEXT;
            dash_reg <= 2'd0;
            tto_reg  <= 1'b0;
            cns_reg  <= 1'b0;
            cnt_reg  <= 3'd0;
            rd_reg   <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            if (s_acc) begin
                mode_reg <= mode_next;
                dash_reg <= dash_next;
                tto_reg  <= tto_next;
                cns_reg  <= cns_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < MAX_RES; i++) begin
                res_reg[i] <= res_new[i];
            end
        end
    end

endmodule

### hdl/htt_checker.sv
module htt_checker
    import htt_pkg::*;
(
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic [7:0]     s_tdata,
    input logic           s_tlast,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [7:0]     m_tdata,
    input logic [U_W-1:0] m_tuser,
    input logic           m_tlast
);

    // a waiting request holds
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("waiting request changed");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // done marker closes its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[U_DONE] |-> m_tlast)
        else $error("done marker without last");

    // done marker carries no token
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[U_DONE] |-> (m_tdata == 8'h00) && !m_tuser[U_BEGIN]
                                        && (m_tuser[U_KIND_LSB +: 2] == KIND_TEXT))
        else $error("done marker with token fields set");

    // nothing pending after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind html_tag_text_tokenizer htt_checker u_htt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
